### hdl/kpdh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpdh_pkg
// Shared constants, control word format and microprogram for the key press
// peak depth histogram.
// ----------------------------------------------------------------------------
package kpdh_pkg;

  localparam int NUM_BINS   = 14;
  localparam int COUNT_BITS = 32;
  localparam int DEPTH_W    = 10;
  localparam int BIN_IDX_W  = $clog2(NUM_BINS);
  localparam int DIV_CNT_W  = (BIN_IDX_W > 1) ? $clog2(BIN_IDX_W) : 1;
  localparam int NUM_W      = DEPTH_W + BIN_IDX_W;
  localparam int PRESS_W    = 32;
  localparam int SUM_W      = 48;
  localparam int OUT_BIN_W  = 32;
  localparam int PC_W       = 4;

  localparam logic [DEPTH_W-1:0] ACT_RST  = 10'd120;
  localparam logic [DEPTH_W-1:0] REL_RST  = 10'd80;
  localparam logic [DEPTH_W-1:0] TRAV_RST = 10'd400;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] REG_ACT  = 2'd0;
  localparam logic [1:0] REG_REL  = 2'd1;
  localparam logic [1:0] REG_TRAV = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_READ_REQ = 4'd1;
  localparam logic [3:0] OP_READ_CAP = 4'd2;
  localparam logic [3:0] OP_CLEAR    = 4'd3;
  localparam logic [3:0] OP_SEL_K0   = 4'd4;
  localparam logic [3:0] OP_FEED     = 4'd5;
  localparam logic [3:0] OP_DIV_INIT = 4'd6;
  localparam logic [3:0] OP_DIV_STEP = 4'd7;
  localparam logic [3:0] OP_BIN_REQ  = 4'd8;
  localparam logic [3:0] OP_BIN_UPD  = 4'd9;
  localparam logic [3:0] OP_SEL_K1   = 4'd10;
  localparam logic [3:0] OP_OUT_LOAD = 4'd11;

  // jump conditions
  localparam logic [3:0] C_NEVER      = 4'd0;
  localparam logic [3:0] C_ALWAYS     = 4'd1;
  localparam logic [3:0] C_NO_ACCEPT  = 4'd2;
  localparam logic [3:0] C_NOT_READ   = 4'd3;
  localparam logic [3:0] C_NOT_CLEAR  = 4'd4;
  localparam logic [3:0] C_NOT_SAMPLE = 4'd5;
  localparam logic [3:0] C_NO_CLOSE   = 4'd6;
  localparam logic [3:0] C_DIV_MORE   = 4'd7;
  localparam logic [3:0] C_KEY1       = 4'd8;
  localparam logic [3:0] C_OUT_BUSY   = 4'd9;

  // program steps
  localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] S_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] S_RD_CAP   = 4'd2;
  localparam logic [PC_W-1:0] S_CHK_CLR  = 4'd3;
  localparam logic [PC_W-1:0] S_CLEAR    = 4'd4;
  localparam logic [PC_W-1:0] S_CHK_SMP  = 4'd5;
  localparam logic [PC_W-1:0] S_FEED     = 4'd6;
  localparam logic [PC_W-1:0] S_DIV_INIT = 4'd7;
  localparam logic [PC_W-1:0] S_DIV_STEP = 4'd8;
  localparam logic [PC_W-1:0] S_BIN_REQ  = 4'd9;
  localparam logic [PC_W-1:0] S_BIN_UPD  = 4'd10;
  localparam logic [PC_W-1:0] S_NEXT_KEY = 4'd11;
  localparam logic [PC_W-1:0] S_SEL_K1   = 4'd12;
  localparam logic [PC_W-1:0] S_DONE     = 4'd15;

  typedef struct packed {
    logic [3:0]      op;
    logic [3:0]      cond;
    logic [PC_W-1:0] target;
  } kpdh_ctrl_t;

  typedef struct packed {
    logic accept;
    logic cmd_read;
    logic cmd_clear;
    logic cmd_sample;
    logic close;
    logic div_more;
    logic key1;
    logic out_busy;
  } kpdh_flags_t;

  function automatic kpdh_ctrl_t ucode(input logic [PC_W-1:0] pc);
    kpdh_ctrl_t w;
    case (pc)
      S_IDLE:     w = '{OP_NOP,      C_NO_ACCEPT,  S_IDLE};
      S_DISPATCH: w = '{OP_READ_REQ, C_NOT_READ,   S_CHK_CLR};
      S_RD_CAP:   w = '{OP_READ_CAP, C_ALWAYS,     S_DONE};
      S_CHK_CLR:  w = '{OP_NOP,      C_NOT_CLEAR,  S_CHK_SMP};
      S_CLEAR:    w = '{OP_CLEAR,    C_ALWAYS,     S_DONE};
      S_CHK_SMP:  w = '{OP_SEL_K0,   C_NOT_SAMPLE, S_DONE};
      S_FEED:     w = '{OP_FEED,     C_NO_CLOSE,   S_NEXT_KEY};
      S_DIV_INIT: w = '{OP_DIV_INIT, C_NEVER,      S_IDLE};
      S_DIV_STEP: w = '{OP_DIV_STEP, C_DIV_MORE,   S_DIV_STEP};
      S_BIN_REQ:  w = '{OP_BIN_REQ,  C_NEVER,      S_IDLE};
      S_BIN_UPD:  w = '{OP_BIN_UPD,  C_NEVER,      S_IDLE};
      S_NEXT_KEY: w = '{OP_NOP,      C_KEY1,       S_DONE};
      S_SEL_K1:   w = '{OP_SEL_K1,   C_ALWAYS,     S_FEED};
      S_DONE:     w = '{OP_OUT_LOAD, C_OUT_BUSY,   S_DONE};
      default:    w = '{OP_NOP,      C_ALWAYS,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/kpdh_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpdh_seq
// Microprogram sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module kpdh_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  kpdh_pkg::kpdh_flags_t    flags,
  output kpdh_pkg::kpdh_ctrl_t     ctrl,
  output logic                     idle
);

  logic [kpdh_pkg::PC_W-1:0] pc_r;
  logic [kpdh_pkg::PC_W-1:0] pc_nxt;
  logic                      taken;

  assign ctrl = kpdh_pkg::ucode(pc_r);
  assign idle = (pc_r == kpdh_pkg::S_IDLE);

  always_comb begin
    case (ctrl.cond)
      kpdh_pkg::C_NEVER:      taken = 1'b0;
      kpdh_pkg::C_ALWAYS:     taken = 1'b1;
      kpdh_pkg::C_NO_ACCEPT:  taken = !flags.accept;
      kpdh_pkg::C_NOT_READ:   taken = !flags.cmd_read;
      kpdh_pkg::C_NOT_CLEAR:  taken = !flags.cmd_clear;
      kpdh_pkg::C_NOT_SAMPLE: taken = !flags.cmd_sample;
      kpdh_pkg::C_NO_CLOSE:   taken = !flags.close;
      kpdh_pkg::C_DIV_MORE:   taken = flags.div_more;
      kpdh_pkg::C_KEY1:       taken = flags.key1;
      kpdh_pkg::C_OUT_BUSY:   taken = flags.out_busy;
      default:                taken = 1'b0;
    endcase
    pc_nxt = taken ? ctrl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= kpdh_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### hdl/keypress_peak_depth_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypress_peak_depth_histogram
// Tracks presses of two analog keys and bins each press peak depth.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one beat per command (sample pair, read bin, clear stats).
//   out_*  : exactly one result beat per input beat, in order.
//   cfg_*  : register writes (actuation, release, travel); always ready.
// Sequencing: a microprogram sequencer runs each command through a shared
//   datapath. A read takes the idle, dispatch, capture and final steps; a
//   clear or the spare command passes the command checks instead; a sample
//   feeds key 0, then key 1, and each closed press adds an overflow check,
//   a bin divide at one quotient bit per cycle, a bin memory read and a
//   write-back. in_ready is high only while the sequencer is idle.
// Result: held in an output register; the next input beat is taken while a
//   result still waits. If out_ready stays low, the sequencer parks at its
//   final step until the register frees.
// Reset: synchronous, active low; clears statistics, bin valid bits, key
//   state and loads default thresholds. No clearing pass is needed.
// ----------------------------------------------------------------------------
module keypress_peak_depth_histogram (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_command,
  input  logic [9:0]   in_depth_key0,
  input  logic [9:0]   in_depth_key1,
  input  logic [3:0]   in_bin_index,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   out_presses_closed,
  output logic [31:0]  out_press_count,
  output logic [47:0]  out_peak_sum,
  output logic [9:0]   out_deepest_peak,
  output logic [31:0]  out_bin_count,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [9:0]   cfg_data
);

  localparam int NB  = kpdh_pkg::NUM_BINS;
  localparam int CB  = kpdh_pkg::COUNT_BITS;
  localparam int DW  = kpdh_pkg::DEPTH_W;
  localparam int BW  = kpdh_pkg::BIN_IDX_W;
  localparam int NW  = kpdh_pkg::NUM_W;
  localparam int SW  = kpdh_pkg::SUM_W;
  localparam int PW  = kpdh_pkg::PRESS_W;
  localparam int OBW = kpdh_pkg::OUT_BIN_W;

  kpdh_pkg::kpdh_ctrl_t  ctrl;
  kpdh_pkg::kpdh_flags_t flags;
  logic                  seq_idle;
  logic                  in_acc;
  logic                  out_busy;

  logic [DW-1:0] act_r, rel_r, trav_r;

  logic [1:0]    cmd_r, cmd_nxt;
  logic [DW-1:0] d0_r, d0_nxt, d1_r, d1_nxt;
  logic [3:0]    idx_r, idx_nxt;

  logic          k_r, k_nxt;
  logic [1:0]    key_down_r, key_down_nxt;
  logic [DW-1:0] key_peak_r [2];
  logic [DW-1:0] key_peak_nxt [2];
  logic          close_f_r, close_f_nxt;
  logic [DW-1:0] close_peak_r, close_peak_nxt;

  logic [NW-1:0]                  rem_r, rem_nxt;
  logic [BW-1:0]                  q_r, q_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [kpdh_pkg::DIV_CNT_W-1:0] div_i_r, div_i_nxt;
  logic [BW-1:0]                  bin_r, bin_nxt;

  logic [1:0]     closed_r, closed_nxt;
  logic [OBW-1:0] bin_out_r, bin_out_nxt;
  logic [PW-1:0]  total_r, total_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [DW-1:0]  max_r, max_nxt;
  logic [NB-1:0]  bin_vld_r, bin_vld_nxt;

  logic [CB-1:0] bin_mem [NB];
  logic [CB-1:0] rd_data_r;
  logic [BW-1:0] mem_ra;
  logic          mem_we;
  logic [CB-1:0] mem_wd;

  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     o_closed_r;
  logic [PW-1:0]  o_total_r;
  logic [SW-1:0]  o_sum_r;
  logic [DW-1:0]  o_max_r;
  logic [OBW-1:0] o_bin_r;

  logic [DW-1:0] cur_d;
  logic          cur_down;
  logic [DW-1:0] cur_pk;
  logic [NW-1:0] num;
  logic [NW-1:0] trav_ext;
  logic [NW-1:0] div_sub;
  logic [BW-1:0] bin_sel;
  logic [CB-1:0] cur_cnt;
  logic [SW:0]   sum_add;
  logic          rd_in_range;
  logic [BW-1:0] rd_idx;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = seq_idle;
  assign out_busy = out_valid_r && !out_ready;
  assign cfg_ready = 1'b1;

  assign flags.accept     = in_acc;
  assign flags.cmd_read   = (cmd_r == kpdh_pkg::CMD_READ);
  assign flags.cmd_clear  = (cmd_r == kpdh_pkg::CMD_CLEAR);
  assign flags.cmd_sample = (cmd_r == kpdh_pkg::CMD_SAMPLE);
  assign flags.close      = close_f_nxt;
  assign flags.div_more   = (div_i_r != '0);
  assign flags.key1       = k_r;
  assign flags.out_busy   = out_busy;

  kpdh_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .idle  (seq_idle)
  );

  assign cur_d    = k_r ? d1_r : d0_r;
  assign cur_down = key_down_r[k_r];
  assign cur_pk   = key_peak_r[k_r];
  assign num      = NW'(close_peak_r) * NW'(NB);
  assign trav_ext = NW'(trav_r);
  assign div_sub  = trav_ext << div_i_r;
  assign bin_sel  = (ovf_r || (int'(q_r) >= NB - 1)) ? BW'(NB - 1) : q_r;
  assign cur_cnt  = bin_vld_r[bin_r] ? rd_data_r : '0;
  assign sum_add  = {1'b0, sum_r} + (SW + 1)'(close_peak_r);
  assign rd_in_range = (int'(idx_r) < NB);
  assign rd_idx   = BW'(idx_r);
  assign mem_ra   = (ctrl.op == kpdh_pkg::OP_BIN_REQ) ? bin_sel : rd_idx;

  always_comb begin
    cmd_nxt        = cmd_r;
    d0_nxt         = d0_r;
    d1_nxt         = d1_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    key_down_nxt   = key_down_r;
    key_peak_nxt   = key_peak_r;
    close_f_nxt    = close_f_r;
    close_peak_nxt = close_peak_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    ovf_nxt        = ovf_r;
    div_i_nxt      = div_i_r;
    bin_nxt        = bin_r;
    closed_nxt     = closed_r;
    bin_out_nxt    = bin_out_r;
    total_nxt      = total_r;
    sum_nxt        = sum_r;
    max_nxt        = max_r;
    bin_vld_nxt    = bin_vld_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_we         = 1'b0;
    mem_wd         = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;

    if (in_acc) begin
      cmd_nxt     = in_command;
      d0_nxt      = in_depth_key0;
      d1_nxt      = in_depth_key1;
      idx_nxt     = in_bin_index;
      closed_nxt  = 2'd0;
      bin_out_nxt = '0;
    end

    case (ctrl.op)
      kpdh_pkg::OP_READ_CAP: begin
        if (rd_in_range && bin_vld_r[rd_idx]) begin
          bin_out_nxt = (64'(rd_data_r) > 64'hFFFF_FFFF) ? '1 : OBW'(rd_data_r);
        end
      end
      kpdh_pkg::OP_CLEAR: begin
        bin_vld_nxt = '0;
        total_nxt   = '0;
        sum_nxt     = '0;
        max_nxt     = '0;
      end
      kpdh_pkg::OP_SEL_K0: begin
        k_nxt = 1'b0;
      end
      kpdh_pkg::OP_SEL_K1: begin
        k_nxt = 1'b1;
      end
      kpdh_pkg::OP_FEED: begin
        close_f_nxt = 1'b0;
        if (!cur_down && (cur_d >= act_r)) begin
          key_down_nxt[k_r] = 1'b1;
          key_peak_nxt[k_r] = cur_d;
        end else if (cur_down && (cur_d > cur_pk)) begin
          key_peak_nxt[k_r] = cur_d;
        end else if (cur_down && (cur_d < rel_r)) begin
          key_down_nxt[k_r] = 1'b0;
          key_peak_nxt[k_r] = '0;
          close_f_nxt       = 1'b1;
          close_peak_nxt    = cur_pk;
        end
      end
      kpdh_pkg::OP_DIV_INIT: begin
        rem_nxt   = num;
        ovf_nxt   = (num >= (trav_ext << BW));
        q_nxt     = '0;
        div_i_nxt = kpdh_pkg::DIV_CNT_W'(BW - 1);
      end
      kpdh_pkg::OP_DIV_STEP: begin
        if (rem_r >= div_sub) begin
          rem_nxt        = rem_r - div_sub;
          q_nxt[div_i_r] = 1'b1;
        end
        div_i_nxt = div_i_r - 1'b1;
      end
      kpdh_pkg::OP_BIN_REQ: begin
        bin_nxt = bin_sel;
      end
      kpdh_pkg::OP_BIN_UPD: begin
        mem_we             = 1'b1;
        bin_vld_nxt[bin_r] = 1'b1;
        closed_nxt         = closed_r + 1'b1;
        if (total_r != '1) begin
          total_nxt = total_r + 1'b1;
        end
        sum_nxt = sum_add[SW] ? '1 : sum_add[SW-1:0];
        if (close_peak_r > max_r) begin
          max_nxt = close_peak_r;
        end
      end
      kpdh_pkg::OP_OUT_LOAD: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[bin_r] <= mem_wd;
    end
    rd_data_r <= bin_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r         <= kpdh_pkg::ACT_RST;
      rel_r         <= kpdh_pkg::REL_RST;
      trav_r        <= kpdh_pkg::TRAV_RST;
      key_down_r    <= '0;
      key_peak_r[0] <= '0;
      key_peak_r[1] <= '0;
      close_f_r     <= 1'b0;
      k_r           <= 1'b0;
      closed_r      <= 2'd0;
      total_r       <= '0;
      sum_r         <= '0;
      max_r         <= '0;
      bin_vld_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kpdh_pkg::REG_ACT:  act_r  <= cfg_data;
          kpdh_pkg::REG_REL:  rel_r  <= cfg_data;
          kpdh_pkg::REG_TRAV: trav_r <= cfg_data;
          default: begin
          end
        endcase
      end
      key_down_r  <= key_down_nxt;
      key_peak_r  <= key_peak_nxt;
      close_f_r   <= close_f_nxt;
      k_r         <= k_nxt;
      closed_r    <= closed_nxt;
      total_r     <= total_nxt;
      sum_r       <= sum_nxt;
      max_r       <= max_nxt;
      bin_vld_r   <= bin_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    d0_r         <= d0_nxt;
    d1_r         <= d1_nxt;
    idx_r        <= idx_nxt;
    close_peak_r <= close_peak_nxt;
    rem_r        <= rem_nxt;
    q_r          <= q_nxt;
    ovf_r        <= ovf_nxt;
    div_i_r      <= div_i_nxt;
    bin_r        <= bin_nxt;
    bin_out_r    <= bin_out_nxt;
    if ((ctrl.op == kpdh_pkg::OP_OUT_LOAD) && !out_busy) begin
      o_closed_r <= closed_r;
      o_total_r  <= total_r;
      o_sum_r    <= sum_r;
      o_max_r    <= max_r;
      o_bin_r    <= bin_out_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_presses_closed = o_closed_r;
  assign out_press_count    = o_total_r;
  assign out_peak_sum       = o_sum_r;
  assign out_deepest_peak   = o_max_r;
  assign out_bin_count      = o_bin_r;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a beat is in progress");

  a_upd_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == kpdh_pkg::OP_BIN_UPD) |-> close_f_r)
    else $error("bin update without a closed press");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == kpdh_pkg::OP_CLEAR) |=>
      (total_r == '0 && sum_r == '0 && max_r == '0 && bin_vld_r == '0))
    else $error("statistics not cleared");

  a_closed_range: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r != 2'd3)
    else $error("more than two presses closed in one beat");
`endif

endmodule

### test/keypress_peak_depth_histogram_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypress_peak_depth_histogram_tb
// Self-checking bench for the two-key press peak depth histogram. A directed
// run covers threshold edges, bin clamping, out-of-range reads, clear with a
// press still open and the spare command. Random traffic follows: key travel
// traces that cross the thresholds, plus noise, reads and clears, under
// several threshold and travel settings. Every result beat is compared with
// a bench-side model of the press statistics.
// ----------------------------------------------------------------------------
module keypress_peak_depth_histogram_tb;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int MAX_WAIT    = 11;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES  = 9;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [9:0] depth0;
    logic [9:0] depth1;
    logic [3:0] bin_sel;
  } key_cmd_t;

  typedef struct packed {
    logic [1:0]  closed;
    logic [31:0] presses;
    logic [47:0] peak_sum;
    logic [9:0]  deepest;
    logic [31:0] bin_count;
  } stat_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = '0;
  logic [9:0]  in_depth_key0 = '0;
  logic [9:0]  in_depth_key1 = '0;
  logic [3:0]  in_bin_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_presses_closed;
  logic [31:0] out_press_count;
  logic [47:0] out_peak_sum;
  logic [9:0]  out_deepest_peak;
  logic [31:0] out_bin_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  keypress_peak_depth_histogram u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_depth_key0      (in_depth_key0),
    .in_depth_key1      (in_depth_key1),
    .in_bin_index       (in_bin_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_presses_closed (out_presses_closed),
    .out_press_count    (out_press_count),
    .out_peak_sum       (out_peak_sum),
    .out_deepest_peak   (out_deepest_peak),
    .out_bin_count      (out_bin_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // press statistics model
  logic [9:0]                      act_level;
  logic [9:0]                      rel_level;
  logic [9:0]                      trav_span;
  logic [1:0]                      key_held;
  logic [9:0]                      key_top [2];
  logic [kpdh_pkg::COUNT_BITS-1:0] bin_tally [kpdh_pkg::NUM_BINS];
  logic [31:0]                     press_total;
  logic [47:0]                     peak_total;
  logic [9:0]                      deepest_seen;

  key_cmd_t   pending_cmds [$];
  stat_beat_t due_results [$];
  int         fault_count = 0;
  int         cycle_count = 0;

  // random key travel traces
  int trace_pos [2];
  int trace_goal [2];
  bit trace_up [2];

  function automatic void wipe_stats();
    for (int i = 0; i < kpdh_pkg::NUM_BINS; i++) bin_tally[i] = '0;
    press_total  = '0;
    peak_total   = '0;
    deepest_seen = '0;
  endfunction

  function automatic logic feed_key(input int k, input logic [9:0] d);
    logic [9:0]  peak;
    logic [63:0] quo;
    int          slot;
    if (!key_held[k] && d >= act_level) begin
      key_held[k] = 1'b1;
      key_top[k]  = d;
      return 1'b0;
    end
    if (key_held[k] && d > key_top[k]) begin
      key_top[k] = d;
      return 1'b0;
    end
    if (!(key_held[k] && d < rel_level)) return 1'b0;
    peak        = key_top[k];
    key_held[k] = 1'b0;
    key_top[k]  = '0;
    slot = kpdh_pkg::NUM_BINS - 1;
    if (trav_span != 0) begin
      quo = (64'(peak) * 64'(kpdh_pkg::NUM_BINS)) / 64'(trav_span);
      if (quo < 64'(kpdh_pkg::NUM_BINS - 1)) slot = int'(quo);
    end
    if (bin_tally[slot] != '1) bin_tally[slot] = bin_tally[slot] + 1'b1;
    if (press_total != '1) press_total = press_total + 1'b1;
    if (48'hFFFF_FFFF_FFFF - peak_total >= 48'(peak)) peak_total = peak_total + 48'(peak);
    else peak_total = '1;
    if (peak > deepest_seen) deepest_seen = peak;
    return 1'b1;
  endfunction

  function automatic stat_beat_t step_stats(input key_cmd_t it);
    stat_beat_t r;
    r = '0;
    case (it.cmd)
      kpdh_pkg::CMD_SAMPLE: begin
        r.closed = 2'(feed_key(0, it.depth0));
        r.closed = r.closed + 2'(feed_key(1, it.depth1));
      end
      kpdh_pkg::CMD_READ: begin
        if (it.bin_sel < kpdh_pkg::NUM_BINS) r.bin_count = 32'(bin_tally[it.bin_sel]);
      end
      kpdh_pkg::CMD_CLEAR: wipe_stats();
      default: ;
    endcase
    r.presses  = press_total;
    r.peak_sum = peak_total;
    r.deepest  = deepest_seen;
    return r;
  endfunction

  function automatic logic [9:0] next_depth(input int k);
    int stride;
    if (trace_pos[k] == trace_goal[k]) begin
      trace_up[k] = !trace_up[k];
      if ($urandom_range(0, 4) == 0) trace_goal[k] = $urandom_range(0, 1023);
      else if (trace_up[k]) trace_goal[k] = $urandom_range(act_level, 1023);
      else trace_goal[k] = (rel_level == 0) ? 0 : $urandom_range(0, rel_level - 1);
    end
    stride = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 160);
    if (trace_goal[k] > trace_pos[k])
      trace_pos[k] = (trace_goal[k] - trace_pos[k] < stride) ? trace_goal[k]
                                                              : trace_pos[k] + stride;
    else
      trace_pos[k] = (trace_pos[k] - trace_goal[k] < stride) ? trace_goal[k]
                                                              : trace_pos[k] - stride;
    return 10'(trace_pos[k]);
  endfunction

  task automatic push_cmd(input logic [1:0] cmd, input logic [9:0] d0, input logic [9:0] d1,
                          input logic [3:0] sel);
    key_cmd_t it;
    it.cmd     = cmd;
    it.depth0  = d0;
    it.depth1  = d1;
    it.bin_sel = sel;
    pending_cmds.push_back(it);
  endtask

  task automatic queue_phase(input int count);
    key_cmd_t it;
    int       pick;
    repeat (count) begin
      pick       = $urandom_range(0, 99);
      it.cmd     = kpdh_pkg::CMD_SAMPLE;
      it.depth0  = 10'($urandom);
      it.depth1  = 10'($urandom);
      it.bin_sel = 4'($urandom);
      if (pick < 76) begin
        it.depth0 = next_depth(0);
        it.depth1 = next_depth(1);
      end else if (pick >= 97) begin
        it.cmd = CMD_SPARE;
      end else if (pick >= 93) begin
        it.cmd = kpdh_pkg::CMD_CLEAR;
      end else if (pick >= 84) begin
        it.cmd     = kpdh_pkg::CMD_READ;
        it.bin_sel = 4'($urandom_range(0, 15));
      end
      pending_cmds.push_back(it);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      kpdh_pkg::REG_ACT:  act_level = val;
      kpdh_pkg::REG_REL:  rel_level = val;
      kpdh_pkg::REG_TRAV: trav_span = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
  endtask

  // input driver
  key_cmd_t live_cmd;
  int       in_hold = 0;
  bit       in_calm = 1'b0;

  always @(posedge clk) begin : drive_in
    int gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_hold  <= 0;
    end else begin
      if (in_valid && in_ready) due_results.push_back(step_stats(live_cmd));
      if (!in_valid || in_ready) begin
        if (in_hold > 0) begin
          in_hold  <= in_hold - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          live_cmd = pending_cmds.pop_front();
          in_command    <= live_cmd.cmd;
          in_depth_key0 <= live_cmd.depth0;
          in_depth_key1 <= live_cmd.depth1;
          in_bin_index  <= live_cmd.bin_sel;
          in_valid      <= 1'b1;
          gap = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
          in_hold <= gap;
          if ($urandom_range(0, 63) == 0) in_calm <= !in_calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int out_hold = 0;
  bit out_calm = 1'b0;

  always @(posedge clk) begin : watch_out
    stat_beat_t want;
    int         stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: result beat with nothing expected: closed=%0d presses=%0d",
                   $realtime, out_presses_closed, out_press_count);
        fault_count = fault_count + 1;
      end else begin
        want = due_results.pop_front();
        if (out_presses_closed !== want.closed || out_press_count !== want.presses ||
            out_peak_sum !== want.peak_sum || out_deepest_peak !== want.deepest ||
            out_bin_count !== want.bin_count) begin
          if (fault_count < 10) begin
            $display("%0t: exp closed=%0d presses=%0d sum=%0d deepest=%0d bin=%0d",
                     $realtime, want.closed, want.presses, want.peak_sum, want.deepest,
                     want.bin_count);
            $display("%0t: got closed=%0d presses=%0d sum=%0d deepest=%0d bin=%0d",
                     $realtime, out_presses_closed, out_press_count, out_peak_sum,
                     out_deepest_peak, out_bin_count);
          end
          fault_count = fault_count + 1;
        end
      end
      stall = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if ($urandom_range(0, 63) == 0) out_calm <= !out_calm;
      out_hold  <= stall;
      out_ready <= (stall == 0);
    end else if (out_hold > 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= (out_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : run
    logic [29:0] levels;
    act_level   = kpdh_pkg::ACT_RST;
    rel_level   = kpdh_pkg::REL_RST;
    trav_span   = kpdh_pkg::TRAV_RST;
    key_held    = '0;
    key_top[0]  = '0;
    key_top[1]  = '0;
    wipe_stats();
    for (int k = 0; k < 2; k++) begin
      trace_pos[k]  = 0;
      trace_goal[k] = 0;
      trace_up[k]   = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed run at reset thresholds
    push_cmd(kpdh_pkg::CMD_READ,   10'd0,    10'd0,    4'd0);
    push_cmd(kpdh_pkg::CMD_READ,   10'd0,    10'd0,    4'd13);
    push_cmd(kpdh_pkg::CMD_READ,   10'd0,    10'd0,    4'd14);
    push_cmd(kpdh_pkg::CMD_READ,   10'd1023, 10'd1023, 4'd15);
    push_cmd(CMD_SPARE,            10'd1023, 10'd1023, 4'd15);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd0,    10'd0,    4'd0);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd120,  10'd119,  4'd0);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd1023, 10'd1023, 4'd0);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd80,   10'd500,  4'd0);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd79,   10'd0,    4'd0);
    push_cmd(kpdh_pkg::CMD_READ,   10'd0,    10'd0,    4'd13);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd399,  10'd120,  4'd0);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd0,    10'd79,   4'd0);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd200,  10'd0,    4'd0);
    push_cmd(kpdh_pkg::CMD_CLEAR,  10'd0,    10'd0,    4'd0);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd0,    10'd0,    4'd0);
    push_cmd(kpdh_pkg::CMD_READ,   10'd0,    10'd0,    4'd7);
    push_cmd(kpdh_pkg::CMD_READ,   10'd0,    10'd0,    4'd4);
    push_cmd(CMD_SPARE,            10'd0,    10'd0,    4'd0);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd1023, 10'd0,    4'd0);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd1022, 10'd1023, 4'd0);
    push_cmd(kpdh_pkg::CMD_SAMPLE, 10'd0,    10'd0,    4'd0);
    push_cmd(kpdh_pkg::CMD_READ,   10'd0,    10'd0,    4'd13);
    queue_phase(PHASE_ITEMS);

    for (int p = 1; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        1: levels = {10'd300, 10'd200, 10'd1023};
        2: levels = {10'd1023, 10'd1023, 10'd1};
        3: levels = {10'd0, 10'd1000, 10'd0};
        4: levels = {10'd500, 10'd600, 10'd0};
        5: levels = {10'd50, 10'd40, 10'd100};
        6: levels = {10'($urandom), 10'($urandom), 10'($urandom)};
        7: levels = {10'd700, 10'd0, 10'd14};
        default: levels = {kpdh_pkg::ACT_RST, kpdh_pkg::REL_RST, kpdh_pkg::TRAV_RST};
      endcase
      write_reg(kpdh_pkg::REG_ACT, levels[29:20]);
      write_reg(kpdh_pkg::REG_REL, levels[19:10]);
      write_reg(kpdh_pkg::REG_TRAV, levels[9:0]);
      queue_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (fault_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
hdl/kpdh_pkg.sv
hdl/kpdh_seq.sv
hdl/keypress_peak_depth_histogram.sv
test/keypress_peak_depth_histogram_tb.sv
